// ===== rtl/hpw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpw_pkg
// Shared types and constants for the projective pixel forward warp unit.
// ----------------------------------------------------------------------------
package hpw_pkg;

  localparam int COEF_W   = 40;             // Q15.24 coefficient
  localparam int COORD_W  = 12;             // source coordinate
  localparam int PROD_W   = COEF_W + COORD_W + 1;
  localparam int ACC_W    = 54;             // u, v, w sums
  localparam int MAG_W    = ACC_W;          // magnitude incl. -2^53
  localparam int QUO_W    = 12;             // quotient bits kept
  localparam int DIV_W    = MAG_W + QUO_W;  // partial remainder width
  localparam int NUM_COEF = 8;
  localparam int ADDR_W   = 6;              // 8 registers, 8 bytes apart

  // register indexes
  localparam logic [2:0] REG_XX = 3'd0;
  localparam logic [2:0] REG_XY = 3'd1;
  localparam logic [2:0] REG_XT = 3'd2;
  localparam logic [2:0] REG_YX = 3'd3;
  localparam logic [2:0] REG_YY = 3'd4;
  localparam logic [2:0] REG_YT = 3'd5;
  localparam logic [2:0] REG_WX = 3'd6;
  localparam logic [2:0] REG_WY = 3'd7;

  localparam logic signed [COEF_W-1:0] Q_ONE_COEF = 40'sd16777216;
  localparam logic signed [ACC_W-1:0]  Q_ONE      = 54'sd16777216;
  localparam logic [7:0]               ALPHA      = 8'hFF;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic [23:0] pixel_rgb;
  } in_beat_t;

  typedef struct packed {
    logic [9:0]  dest_x;
    logic [9:0]  dest_y;
    logic [19:0] dest_address;
    logic [31:0] pixel_argb;
  } out_beat_t;

  // per-stage divider status
  typedef struct packed {
    logic             ovf;   // quotient >= 2^QUO_W
    logic             neg;   // signs differ
    logic             zero;  // denominator is zero
    logic [QUO_W-1:0] quo;
  } div_res_t;

endpackage

// ===== rtl/hpw_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpw_mac
// Two-stage multiply-accumulate: six coefficient products, then u, v, w.
// ----------------------------------------------------------------------------
module hpw_mac (
  input  logic                  clk,
  input  logic [11:0]           src_x,
  input  logic [11:0]           src_y,
  input  hpw_pkg::coef_t        coef [hpw_pkg::NUM_COEF],
  output hpw_pkg::acc_t         u,
  output hpw_pkg::acc_t         v,
  output hpw_pkg::acc_t         w
);
  import hpw_pkg::*;

  logic signed [PROD_W-1:0] prod_r [6];
  logic signed [PROD_W-1:0] prod_nxt [6];
  acc_t u_r, v_r, w_r;
  logic signed [COORD_W:0] sx, sy;

  // stage 1: products (the user must hold coefficients still while items are in flight; the block does not enforce it)
  always_comb begin
    sx = $signed({1'b0, src_x});
    sy = $signed({1'b0, src_y});
    prod_nxt[0] = coef[REG_XX] * sx;
    prod_nxt[1] = coef[REG_XY] * sy;
    prod_nxt[2] = coef[REG_YX] * sx;
    prod_nxt[3] = coef[REG_YY] * sy;
    prod_nxt[4] = coef[REG_WX] * sx;
    prod_nxt[5] = coef[REG_WY] * sy;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // stage 2: three-input sums, exact in 54 bits
  always_ff @(posedge clk) begin
    u_r <= ACC_W'(prod_r[0]) + ACC_W'(prod_r[1]) + ACC_W'(coef[REG_XT]);
    v_r <= ACC_W'(prod_r[2]) + ACC_W'(prod_r[3]) + ACC_W'(coef[REG_YT]);
    w_r <= ACC_W'(prod_r[4]) + ACC_W'(prod_r[5]) + Q_ONE;
  end

  assign u = u_r;
  assign v = v_r;
  assign w = w_r;

endmodule

// ===== rtl/hpw_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpw_div
// Pipelined restoring divider: one setup stage, then one quotient bit per
// stage. Quotients of 2^QUO_W and above are flagged, not computed.
// ----------------------------------------------------------------------------
module hpw_div (
  input  logic             clk,
  input  hpw_pkg::acc_t    num,
  input  hpw_pkg::acc_t    den,
  output hpw_pkg::div_res_t res
);
  import hpw_pkg::*;

  logic [DIV_W-1:0] rem_r [QUO_W+1];
  logic [MAG_W-1:0] dsr_r [QUO_W+1];
  div_res_t         st_r  [QUO_W+1];

  logic [MAG_W-1:0] mag_n, mag_d;

  // setup: magnitudes, sign, overflow and zero checks
  always_comb begin
    mag_n = num[ACC_W-1] ? MAG_W'(-num) : MAG_W'(num);
    mag_d = den[ACC_W-1] ? MAG_W'(-den) : MAG_W'(den);
  end

  always_ff @(posedge clk) begin
    rem_r[0]     <= DIV_W'(mag_n);
    dsr_r[0]     <= mag_d;
    st_r[0].ovf  <= DIV_W'(mag_n) >= (DIV_W'(mag_d) << QUO_W);
    st_r[0].neg  <= num[ACC_W-1] ^ den[ACC_W-1];
    st_r[0].zero <= (den == '0);
    st_r[0].quo  <= '0;
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    localparam int BIT = QUO_W - 1 - s;
    logic [DIV_W:0]   diff;
    logic [DIV_W-1:0] rem_nxt;
    div_res_t         st_nxt;

    always_comb begin
      diff    = {1'b0, rem_r[s]} - ((DIV_W+1)'(dsr_r[s]) << BIT);
      st_nxt  = st_r[s];
      rem_nxt = rem_r[s];
      if (!diff[DIV_W]) begin
        rem_nxt         = diff[DIV_W-1:0];
        st_nxt.quo[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s+1] <= rem_nxt;
      dsr_r[s+1] <= dsr_r[s];
      st_r[s+1]  <= st_nxt;
    end
  end

  assign res = st_r[QUO_W];

endmodule

// ===== rtl/projective_pixel_forward_warp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projective_pixel_forward_warp_unit
// Maps each source pixel through a 3x3 homography (Q15.24 coefficients),
// divides by w with truncation and emits pixels that land in the target.
// Pipeline: 2 MAC stages, 13 divider stages and 1 output register.
// Throughput: one pixel per cycle; busy is never raised.
// The divider pipeline retires one quotient bit per stage over 12 stages.
// Reset clears valid bits and loads the identity homography.
// ----------------------------------------------------------------------------
module projective_pixel_forward_warp_unit #(
  parameter int DEST_WIDTH  = 1024,
  parameter int DEST_HEIGHT = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // pixel input
  input  logic                        start,
  output logic                        busy,
  input  hpw_pkg::in_beat_t           in_data,
  // result output
  output logic                        out_valid,
  output hpw_pkg::out_beat_t          out_data,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hpw_pkg::ADDR_W-1:0]  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  import hpw_pkg::*;

  localparam int PIPE = QUO_W + 3;  // MAC + divider stages

  coef_t     coef_r [NUM_COEF];
  logic      vld_r  [PIPE];
  logic [23:0] rgb_r [PIPE];
  acc_t      u, v, w;
  div_res_t  res_u, res_v;
  logic      in_x, in_y, hit;
  logic [24:0] addr_full;
  logic      out_valid_r;
  out_beat_t out_data_r;
  logic [2:0] widx;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign widx   = paddr[ADDR_W-1:3];

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) coef_r[i] <= '0;
      coef_r[REG_XX] <= Q_ONE_COEF;
      coef_r[REG_YY] <= Q_ONE_COEF;
    end else if (psel && penable && pwrite) begin
      coef_r[widx] <= pwdata[COEF_W-1:0];
    end
  end

  assign prdata = 64'(coef_r[widx]);

  // valid and color travel alongside the arithmetic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= start;
      for (int i = 1; i < PIPE; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    rgb_r[0] <= in_data.pixel_rgb;
    for (int i = 1; i < PIPE; i++) rgb_r[i] <= rgb_r[i-1];
  end

  hpw_mac u_mac (
    .clk   (clk),
    .src_x (in_data.src_x),
    .src_y (in_data.src_y),
    .coef  (coef_r),
    .u     (u),
    .v     (v),
    .w     (w)
  );

  hpw_div u_div_x (.clk(clk), .num(u), .den(w), .res(res_u));
  hpw_div u_div_y (.clk(clk), .num(v), .den(w), .res(res_v));

  // range check and address
  always_comb begin
    in_x = !res_u.zero && !res_u.ovf &&
           ((res_u.quo == '0) ||
            (!res_u.neg && ({1'b0, res_u.quo} < (QUO_W+1)'(DEST_WIDTH))));
    in_y = !res_v.zero && !res_v.ovf &&
           ((res_v.quo == '0) ||
            (!res_v.neg && ({1'b0, res_v.quo} < (QUO_W+1)'(DEST_HEIGHT))));
    hit  = vld_r[PIPE-1] && in_x && in_y;
    addr_full = 25'(res_v.quo) * 25'(DEST_WIDTH) + 25'(res_u.quo);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= hit;
  end

  always_ff @(posedge clk) begin
    out_data_r.dest_x       <= res_u.quo[9:0];
    out_data_r.dest_y       <= res_v.quo[9:0];
    out_data_r.dest_address <= addr_full[19:0];
    out_data_r.pixel_argb   <= {ALPHA, rgb_r[PIPE-1]};
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/hpw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpw_checker
// Port-level checks of the warp unit: timing, color pass-through, address.
// ----------------------------------------------------------------------------
module hpw_checker #(
  parameter int DEST_WIDTH  = 1024,
  parameter int DEST_HEIGHT = 1024
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input hpw_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input hpw_pkg::out_beat_t out_data
);
  import hpw_pkg::*;

  localparam int LAT = QUO_W + 4;

  logic [23:0] addr_chk;
  assign addr_chk = 24'(out_data.dest_y) * 24'(DEST_WIDTH) + 24'(out_data.dest_x);

  // a result beat only follows an accepted beat through the pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching input beat");

  // color carried from the same input beat, alpha opaque
  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pixel_argb[23:0] == $past(in_data.pixel_rgb, LAT)) &&
                  (out_data.pixel_argb[31:24] == ALPHA))
    else $error("pixel color mismatch");

  // address consistent with coordinates (narrow targets only)
  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && DEST_WIDTH <= 1024 && DEST_HEIGHT <= 1024) |->
      (out_data.dest_address == addr_chk[19:0]))
    else $error("address does not match coordinates");

  // the unit never pushes back
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

endmodule

bind projective_pixel_forward_warp_unit hpw_checker #(
  .DEST_WIDTH (DEST_WIDTH),
  .DEST_HEIGHT(DEST_HEIGHT)
) u_hpw_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_data (out_data)
);
